>>> rtl/hsvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_pkg
// Types and constants shared by the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvc_pkg;

    typedef logic [8:0]  hue_t;
    typedef logic [7:0]  chan_t;
    typedef logic [2:0]  sector_t;
    typedef logic [5:0]  frac_t;
    typedef logic [13:0] lvl_num_t;   // numerator, up to 15300
    typedef logic [15:0] prod_p_t;    // V * (255 - S)
    typedef logic [21:0] prod_qt_t;   // V * numerator, up to 255 * 15300

    // Hue sector boundaries in degrees
    localparam hue_t HUE_60  = 9'd60;
    localparam hue_t HUE_120 = 9'd120;
    localparam hue_t HUE_180 = 9'd180;
    localparam hue_t HUE_240 = 9'd240;
    localparam hue_t HUE_300 = 9'd300;
    localparam hue_t HUE_360 = 9'd360;

    // Sector codes; SECTOR_6 is hue 360, routed like sector 5
    localparam sector_t SECTOR_0 = 3'd0;
    localparam sector_t SECTOR_1 = 3'd1;
    localparam sector_t SECTOR_2 = 3'd2;
    localparam sector_t SECTOR_3 = 3'd3;
    localparam sector_t SECTOR_4 = 3'd4;
    localparam sector_t SECTOR_5 = 3'd5;
    localparam sector_t SECTOR_6 = 3'd6;

    localparam chan_t    CHAN_FULL   = 8'd255;
    localparam logic [6:0] SECTOR_DEG = 7'd60;
    localparam lvl_num_t LVL_SCALE   = 14'd15300;   // 255 * 60

    // Reciprocals: floor(2^16 / 255) and floor(2^22 / 15300)
    localparam logic [8:0] RECIP_FULL  = 9'd257;
    localparam logic [8:0] RECIP_SCALE = 9'd274;

endpackage

>>> rtl/hsvc_hsv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_hsv_if
// Valid/ready channel carrying one HSV word.
// ----------------------------------------------------------------------------
interface hsvc_hsv_if import hsvc_pkg::*; ();

    logic  valid;
    logic  ready;
    hue_t  hue;
    chan_t saturation;
    chan_t brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);

endinterface

>>> rtl/hsvc_rgb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_rgb_if
// Valid/ready channel carrying one RGB word.
// ----------------------------------------------------------------------------
interface hsvc_rgb_if import hsvc_pkg::*; ();

    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;

    modport source (output valid, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    output ready);

endinterface

>>> rtl/hsvc_sector_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_sector_decode
// Clamps hue to 360 and splits it into sector (hue / 60) and remainder.
// ----------------------------------------------------------------------------
module hsvc_sector_decode import hsvc_pkg::*; (
    input  hue_t    hue,
    output sector_t sector,
    output frac_t   frac
);

    hue_t hue_base;
    hue_t hue_off;

    // compare ladder replaces the divide by 60
    always_comb
    begin
        if (hue >= HUE_360)
        begin
            sector   = SECTOR_6;
            hue_base = hue;          // clamped: remainder forced to zero
        end
        else if (hue >= HUE_300)
        begin
            sector   = SECTOR_5;
            hue_base = HUE_300;
        end
        else if (hue >= HUE_240)
        begin
            sector   = SECTOR_4;
            hue_base = HUE_240;
        end
        else if (hue >= HUE_180)
        begin
            sector   = SECTOR_3;
            hue_base = HUE_180;
        end
        else if (hue >= HUE_120)
        begin
            sector   = SECTOR_2;
            hue_base = HUE_120;
        end
        else if (hue >= HUE_60)
        begin
            sector   = SECTOR_1;
            hue_base = HUE_60;
        end
        else
        begin
            sector   = SECTOR_0;
            hue_base = 9'd0;
        end
    end

    assign hue_off = hue - hue_base;
    assign frac    = hue_off[5:0];

endmodule

>>> rtl/hsv_to_rgb_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// HSV to RGB color converter, five stages, one word per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one HSV word (hue 0..360 degrees, larger hues clamp to 360; saturation
// and brightness 0..255) and returns red, green and blue bytes computed with
// exact floor fixed point: p = V*(255-S)/255, q = V*(15300-S*F)/15300,
// t = V*(15300-S*(60-F))/15300, F = hue mod 60. Zero saturation yields grey
// without a special path because p = q = t = V then. Throughput is one word
// per clock while rgb.ready stays high; each word passes through five
// register stages, the first of which is loaded at the edge that accepts it.
// The stages are: sector decode, numerators (S*F products), level products (V
// times numerator), reciprocal estimate of the divide by a constant, and
// remainder correction with channel routing into the output register. Each
// stage holds its own valid bit and only stalls when the stage after it is
// full and stalled, so bubbles are squeezed out and an output word waiting
// on rgb.ready does not block intake while earlier stages have room.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top import hsvc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    hsvc_hsv_if.sink    hsv,
    hsvc_rgb_if.source  rgb
);

    // ------------------------------------------------------------------
    // Flow control: stage k loads when it is empty or stage k+1 loads.
    // ------------------------------------------------------------------
    logic [4:0] stage_valid_reg;
    logic [4:0] stage_valid_next;
    logic [4:0] stage_en;

    assign stage_en[4] = !stage_valid_reg[4] || rgb.ready;
    assign stage_en[3] = !stage_valid_reg[3] || stage_en[4];
    assign stage_en[2] = !stage_valid_reg[2] || stage_en[3];
    assign stage_en[1] = !stage_valid_reg[1] || stage_en[2];
    assign stage_en[0] = !stage_valid_reg[0] || stage_en[1];

    assign hsv.ready = stage_en[0];

    assign stage_valid_next = {stage_valid_reg[3:0], hsv.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < 5; k++)
            begin
                if (stage_en[k])
                begin
                    stage_valid_reg[k] <= stage_valid_next[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp and sector decode
    // ------------------------------------------------------------------
    sector_t s1_sector_reg, s1_sector_next;
    frac_t   s1_frac_reg,   s1_frac_next;
    chan_t   s1_sat_reg;
    chan_t   s1_val_reg;

    hsvc_sector_decode u_decode (
        .hue    (hsv.hue),
        .sector (s1_sector_next),
        .frac   (s1_frac_next)
    );

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s1_sector_reg <= s1_sector_next;
            s1_frac_reg   <= s1_frac_next;
            s1_sat_reg    <= hsv.saturation;
            s1_val_reg    <= hsv.brightness;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: numerators 255-S, 15300-S*F, 15300-S*(60-F)
    // ------------------------------------------------------------------
    logic [6:0] inv_frac;
    lvl_num_t   sat_frac;
    lvl_num_t   sat_inv_frac;
    chan_t      s2_np_reg,  s2_np_next;
    lvl_num_t   s2_nq_reg,  s2_nq_next;
    lvl_num_t   s2_nt_reg,  s2_nt_next;
    sector_t    s2_sector_reg;
    chan_t      s2_val_reg;

    assign inv_frac     = SECTOR_DEG - {1'b0, s1_frac_reg};
    assign sat_frac     = 14'(s1_sat_reg) * 14'(s1_frac_reg);
    assign sat_inv_frac = 14'(s1_sat_reg) * 14'(inv_frac);   // at most 15300
    assign s2_np_next   = CHAN_FULL - s1_sat_reg;
    assign s2_nq_next   = LVL_SCALE - sat_frac;
    assign s2_nt_next   = LVL_SCALE - sat_inv_frac;

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s2_np_reg     <= s2_np_next;
            s2_nq_reg     <= s2_nq_next;
            s2_nt_reg     <= s2_nt_next;
            s2_sector_reg <= s1_sector_reg;
            s2_val_reg    <= s1_val_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: products V * numerator
    // ------------------------------------------------------------------
    prod_p_t  s3_pp_reg, s3_pp_next;
    prod_qt_t s3_pq_reg, s3_pq_next;
    prod_qt_t s3_pt_reg, s3_pt_next;
    sector_t  s3_sector_reg;
    chan_t    s3_val_reg;

    assign s3_pp_next = 16'(s2_val_reg) * 16'(s2_np_reg);
    assign s3_pq_next = 22'(s2_val_reg) * 22'(s2_nq_reg);
    assign s3_pt_next = 22'(s2_val_reg) * 22'(s2_nt_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            s3_pp_reg     <= s3_pp_next;
            s3_pq_reg     <= s3_pq_next;
            s3_pt_reg     <= s3_pt_next;
            s3_sector_reg <= s2_sector_reg;
            s3_val_reg    <= s2_val_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: quotient estimate by reciprocal multiply. The reciprocals
    // are rounded down, so the estimate is the true floor or one below.
    // ------------------------------------------------------------------
    logic [24:0] est_p_full;
    logic [30:0] est_q_full;
    logic [30:0] est_t_full;
    chan_t       s4_ep_reg, s4_eq_reg, s4_et_reg;
    prod_p_t     s4_pp_reg;
    prod_qt_t    s4_pq_reg, s4_pt_reg;
    sector_t     s4_sector_reg;
    chan_t       s4_val_reg;

    assign est_p_full = 25'(s3_pp_reg) * 25'(RECIP_FULL);
    assign est_q_full = 31'(s3_pq_reg) * 31'(RECIP_SCALE);
    assign est_t_full = 31'(s3_pt_reg) * 31'(RECIP_SCALE);

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            s4_ep_reg     <= est_p_full[23:16];
            s4_eq_reg     <= est_q_full[29:22];
            s4_et_reg     <= est_t_full[29:22];
            s4_pp_reg     <= s3_pp_reg;
            s4_pq_reg     <= s3_pq_reg;
            s4_pt_reg     <= s3_pt_reg;
            s4_sector_reg <= s3_sector_reg;
            s4_val_reg    <= s3_val_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: remainder check bumps the estimate by one, then route the
    // levels to the channels by sector.
    // ------------------------------------------------------------------
    prod_p_t  rem_p;
    prod_qt_t rem_q;
    prod_qt_t rem_t;
    chan_t    lvl_p, lvl_q, lvl_t;
    chan_t    red_reg,   red_next;
    chan_t    green_reg, green_next;
    chan_t    blue_reg,  blue_next;

    assign rem_p = s4_pp_reg - 16'(s4_ep_reg) * 16'(CHAN_FULL);
    assign rem_q = s4_pq_reg - 22'(s4_eq_reg) * 22'(LVL_SCALE);
    assign rem_t = s4_pt_reg - 22'(s4_et_reg) * 22'(LVL_SCALE);

    assign lvl_p = (rem_p >= 16'(CHAN_FULL)) ? s4_ep_reg + 8'd1 : s4_ep_reg;
    assign lvl_q = (rem_q >= 22'(LVL_SCALE)) ? s4_eq_reg + 8'd1 : s4_eq_reg;
    assign lvl_t = (rem_t >= 22'(LVL_SCALE)) ? s4_et_reg + 8'd1 : s4_et_reg;

    always_comb
    begin
        case (s4_sector_reg)
            SECTOR_0:
            begin
                red_next = s4_val_reg; green_next = lvl_t; blue_next = lvl_p;
            end
            SECTOR_1:
            begin
                red_next = lvl_q; green_next = s4_val_reg; blue_next = lvl_p;
            end
            SECTOR_2:
            begin
                red_next = lvl_p; green_next = s4_val_reg; blue_next = lvl_t;
            end
            SECTOR_3:
            begin
                red_next = lvl_p; green_next = lvl_q; blue_next = s4_val_reg;
            end
            SECTOR_4:
            begin
                red_next = lvl_t; green_next = lvl_p; blue_next = s4_val_reg;
            end
            default:
            begin
                // sector 5 and hue 360
                red_next = s4_val_reg; green_next = lvl_p; blue_next = lvl_q;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.valid = stage_valid_reg[4];
    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;

endmodule
